FILE: rtl/ssrv_pkg.sv
// Package: ring constants, action codes, gain helper and pipeline types for the sample ring.
package ssrv_pkg;

   // Ring geometry
   localparam int RING_DEPTH = 8192;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int FILL_W     = $clog2(RING_DEPTH + 1);
   localparam int LEVEL_W    = 14;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int PAIR_W   = 2 * SAMPLE_W;
   localparam int PCT_W    = 7;
   localparam int GAIN_W   = 6;
   localparam int CSR_W    = 7;

   // Action codes
   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_PULL = 2'd1;
   localparam logic [1:0] ACT_MUTE = 2'd2;

   // Register indexes
   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_VOLUME = 1'b1;

   localparam logic [PCT_W-1:0]  PCT_MAX    = 7'd100;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 6'd6;   // gain for 20 percent

   // Gain = floor(min(pct,100) * 32 / 100), by reciprocal: floor(p * 328 / 1024)
   function automatic logic [GAIN_W-1:0] gain_of(input logic [PCT_W-1:0] pct);
      logic [PCT_W-1:0] sat;
      logic [16:0]      prod;
      sat  = (pct > PCT_MAX) ? PCT_MAX : pct;
      prod = 17'(sat) * 17'd328;
      return prod[15:10];
   endfunction

   // Status carried from the accept stage to the output register
   typedef struct packed {
      logic                 out_valid;
      logic                 use_mem;
      logic                 underrun;
      logic                 dropped;
      logic                 amp_enable;
      logic [LEVEL_W-1:0]   fill_level;
   } stage_type;

endpackage

FILE: rtl/ssrv_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ssrv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/stereo_sample_ring_with_volume.sv
// Stereo sample ring with volume scaling on push, pull with underrun and amplifier control.
// Pipeline: an accepted item passes the accept stage with the ring read, then the output register.
// Throughput: one item per cycle while rsp_stall is low; the single ring read port and write port serve one item each.
// Reset: synchronous; indexes, fill count, amplifier enable and block enable clear, volume
// returns to 20 percent. Ring contents are not cleared; only written entries are ever read.
module stereo_sample_ring_with_volume
   import ssrv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_wr_en,
   input  logic                       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata,
   // input items
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_action,
   input  logic signed [SAMPLE_W-1:0] req_left_in,
   input  logic signed [SAMPLE_W-1:0] req_right_in,
   input  logic                       req_mute_value,
   // result items
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_out_valid,
   output logic signed [SAMPLE_W-1:0] rsp_out_left,
   output logic signed [SAMPLE_W-1:0] rsp_out_right,
   output logic                       rsp_underrun,
   output logic                       rsp_dropped,
   output logic                       rsp_amp_enable,
   output logic [LEVEL_W-1:0]         rsp_fill_level
);

   // Configuration registers
   logic              enable_ff;
   logic [GAIN_W-1:0] gain_ff;

   // Ring control state
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              amp_ff, amp_in;

   // Pipeline
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      out_valid_ff;
   stage_type out_ff;
   logic [PAIR_W-1:0] out_pair_ff;

   logic accept;
   logic advance;
   logic full;
   logic empty;
   logic mem_wr;
   logic mem_rd;
   logic [PAIR_W-1:0] rd_pair;
   logic [SAMPLE_W-1:0] left_scaled;
   logic [SAMPLE_W-1:0] right_scaled;
   logic [FILL_W+LEVEL_W-1:0] fill_wide;

   // Scale one sample: s*g/32 truncated toward zero, saturated to 16 bits
   function automatic logic [SAMPLE_W-1:0] scale(input logic signed [SAMPLE_W-1:0] s,
                                                 input logic [GAIN_W-1:0] g);
      logic signed [SAMPLE_W+GAIN_W:0] prod;
      logic signed [SAMPLE_W+GAIN_W:0] biased;
      logic signed [SAMPLE_W+GAIN_W:0] quot;
      prod   = s * $signed({1'b0, g});
      biased = prod[SAMPLE_W+GAIN_W] ? prod + (SAMPLE_W+GAIN_W+1)'(31) : prod;
      quot   = biased >>> 5;
      if (quot > (SAMPLE_W+GAIN_W+1)'(32767)) begin
         return 16'h7FFF;
      end else if (quot < -(SAMPLE_W+GAIN_W+1)'(32768)) begin
         return 16'h8000;
      end
      return quot[SAMPLE_W-1:0];
   endfunction

   // Handshake: the accept stage moves on when the output register is free or being taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign full  = (fill_ff == FILL_W'(RING_DEPTH));
   assign empty = (fill_ff == '0);

   assign left_scaled  = scale(req_left_in, gain_ff);
   assign right_scaled = scale(req_right_in, gain_ff);

   // Decode the item, update ring control state
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      fill_in   = fill_ff;
      amp_in    = amp_ff;
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      s1_in     = '0;
      if (accept && enable_ff) begin
         unique case (req_action)
            ACT_PUSH: begin
               amp_in = 1'b1;
               if (full) begin
                  s1_in.dropped = 1'b1;
               end else begin
                  mem_wr    = 1'b1;
                  wr_idx_in = (wr_idx_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
                  fill_in   = fill_ff + 1'b1;
               end
            end
            ACT_PULL: begin
               s1_in.out_valid = 1'b1;
               if (empty) begin
                  s1_in.underrun = 1'b1;
               end else begin
                  mem_rd        = 1'b1;
                  s1_in.use_mem = 1'b1;
                  rd_idx_in = (rd_idx_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
                  fill_in   = fill_ff - 1'b1;
               end
            end
            ACT_MUTE: begin
               amp_in = !req_mute_value;
            end
            default: begin
            end
         endcase
      end
      fill_wide        = {{LEVEL_W{1'b0}}, fill_in};
      s1_in.amp_enable = amp_in;
      s1_in.fill_level = fill_wide[LEVEL_W-1:0];
   end

   assign s1_valid_in = accept || (s1_valid_ff && !advance);

   // Ring storage: right sample in the high half, left in the low half
   ssrv_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_idx_ff),
      .wr_data ({right_scaled, left_scaled}),
      .rd_en   (mem_rd),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_pair)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         gain_ff   <= GAIN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_VOLUME: gain_ff   <= gain_of(csr_wdata[PCT_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   // Ring control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
         amp_ff    <= 1'b0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
         amp_ff    <= amp_in;
      end
   end

   // Accept stage: hold while the output register is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // Output register: load from the accept stage, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_ff      <= s1_ff;
         out_pair_ff <= s1_ff.use_mem ? rd_pair : '0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_valid  = out_ff.out_valid;
   assign rsp_out_left   = out_pair_ff[SAMPLE_W-1:0];
   assign rsp_out_right  = out_pair_ff[PAIR_W-1:SAMPLE_W];
   assign rsp_underrun   = out_ff.underrun;
   assign rsp_dropped    = out_ff.dropped;
   assign rsp_amp_enable = out_ff.amp_enable;
   assign rsp_fill_level = out_ff.fill_level;

   // Fill count never passes the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(RING_DEPTH))
      else $error("ring fill count above depth");

   // No ring write while the ring is full
   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      mem_wr |-> !full)
      else $error("ring written while full");

   // An item waiting in the accept stage is not lost while the output stalls
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("accept stage lost an item under stall");

   // Pull data is read only from a nonempty ring
   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      mem_rd |-> !empty)
      else $error("ring read while empty");

endmodule
